// ===== sv/fbpa_pkg.sv =====
package fbpa_pkg;

    // Field widths fixed by the port list.
    localparam int HANDLE_W    = 12;
    localparam int ADDR_W      = 20;
    localparam int DATA_W      = 13;
    localparam int PAGE_W      = 17;
    localparam int ALIGN_W     = 4;
    localparam int PAGES_OUT_W = 5;
    localparam int COUNT_W     = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;

    // Block size reaches 32768 when the alignment exponent is at its top code.
    localparam int BSIZE_W = 16;
    // Blocks per page never exceed the handle space, so 4096 is the ceiling.
    localparam int BPP_W   = HANDLE_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration register indices.
    localparam logic [CFG_INDEX_W-1:0] CFG_DATA_BYTES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_BYTES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALIGN_LOG2 = 2'd2;

    // Register values after reset.
    localparam logic [DATA_W-1:0]  DATA_BYTES_RST = 13'd8;
    localparam logic [PAGE_W-1:0]  PAGE_BYTES_RST = 17'd4096;
    localparam logic [ALIGN_W-1:0] ALIGN_LOG2_RST = 4'd3;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_ALLOCATED  = 2'd0,
        ST_FREED      = 2'd1,
        ST_NO_PAGES   = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CARVE,
        BK_SETTLE,
        BK_POP,
        BK_DONE
    } back_state_t;

    // A request after the front has split the handle into page and index.
    typedef struct packed {
        func_t               func;
        logic [HANDLE_W-1:0] page;
        logic [HANDLE_W-1:0] idx;
    } req_t;

    // Pool geometry and control from the configuration unit.
    typedef struct packed {
        logic               busy;
        logic               clear;
        logic [BSIZE_W-1:0] block_size;
        logic [PAGE_W-1:0]  page_bytes;
        logic [BPP_W-1:0]   blocks_per_page;
    } geom_t;

    typedef struct packed {
        status_t                status;
        logic [HANDLE_W-1:0]    handle;
        logic [ADDR_W-1:0]      addr;
        logic [PAGES_OUT_W-1:0] pages;
        logic [COUNT_W-1:0]     total;
        logic [COUNT_W-1:0]     free;
    } result_t;

endpackage

// ===== sv/fbpa_cfg.sv =====
module fbpa_cfg #(
    parameter int MAX_BLOCKS_PER_PAGE = 256,
    parameter int BLOCK_HEADER_BYTES  = 8,
    parameter int PAGE_HEADER_BYTES   = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_data,
    output fbpa_pkg::geom_t                    geom
);

    import fbpa_pkg::*;

    localparam int DIV_STEPS = PAGE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam int SUM_W     = 17;

    logic [DATA_W-1:0]   data_bytes_reg;
    logic [PAGE_W-1:0]   page_bytes_reg;
    logic [ALIGN_W-1:0]  align_log2_reg;
    logic                start_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [PAGE_W-1:0]   dvd_reg;
    logic [BSIZE_W-1:0]  rem_reg;
    logic [PAGE_W-1:0]   quo_reg;
    logic [BSIZE_W-1:0]  size_reg;
    logic [BPP_W-1:0]    bpp_reg;

    logic                cfg_write;
    logic                we_data, we_page, we_align;
    logic [DATA_W-1:0]   need;
    logic [SUM_W-1:0]    align_mask;
    logic [SUM_W-1:0]    size_full;
    logic [BSIZE_W-1:0]  size_next;
    logic [PAGE_W-1:0]   avail;
    logic [BSIZE_W:0]    rem_shift;
    logic [BSIZE_W:0]    rem_sub;
    logic                fits;
    logic [BSIZE_W-1:0]  rem_next;
    logic [PAGE_W-1:0]   quo_next;
    logic [BPP_W-1:0]    bpp_next;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        we_data  = 1'b0;
        we_page  = 1'b0;
        we_align = 1'b0;
        unique case (cfg_index)
            CFG_DATA_BYTES: we_data  = cfg_write;
            CFG_PAGE_BYTES: we_page  = cfg_write;
            CFG_ALIGN_LOG2: we_align = cfg_write;
            default:        ;
        endcase
    end

    // Block size: payload or block header, whichever is larger, rounded up.
    always_comb
    begin
        need       = (data_bytes_reg > DATA_W'(BLOCK_HEADER_BYTES))
                   ? data_bytes_reg : DATA_W'(BLOCK_HEADER_BYTES);
        align_mask = (SUM_W'(1) << align_log2_reg) - SUM_W'(1);
        size_full  = (SUM_W'(need) + align_mask) & ~align_mask;
        size_next  = BSIZE_W'(size_full);
        avail      = (page_bytes_reg > PAGE_W'(PAGE_HEADER_BYTES))
                   ? page_bytes_reg - PAGE_W'(PAGE_HEADER_BYTES) : '0;
    end

    // One quotient bit per cycle, restoring division.
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[PAGE_W-1]};
        rem_sub   = rem_shift - {1'b0, size_reg};
        fits      = rem_shift >= {1'b0, size_reg};
        rem_next  = fits ? rem_sub[BSIZE_W-1:0] : rem_shift[BSIZE_W-1:0];
        quo_next  = {quo_reg[PAGE_W-2:0], fits};
        bpp_next  = (quo_next > PAGE_W'(MAX_BLOCKS_PER_PAGE))
                  ? BPP_W'(MAX_BLOCKS_PER_PAGE) : BPP_W'(quo_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_bytes_reg <= DATA_BYTES_RST;
            page_bytes_reg <= PAGE_BYTES_RST;
            align_log2_reg <= ALIGN_LOG2_RST;
            start_reg      <= 1'b1;
            step_reg       <= '0;
        end
        else
        begin
            if (we_data)
            begin
                data_bytes_reg <= cfg_data[DATA_W-1:0];
            end
            if (we_page)
            begin
                page_bytes_reg <= cfg_data[PAGE_W-1:0];
            end
            if (we_align)
            begin
                align_log2_reg <= cfg_data[ALIGN_W-1:0];
            end
            if (we_data || we_page || we_align)
            begin
                start_reg <= 1'b1;
                step_reg  <= '0;
            end
            else if (start_reg)
            begin
                start_reg <= 1'b0;
                step_reg  <= STEP_W'(DIV_STEPS);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_reg)
        begin
            size_reg <= size_next;
            dvd_reg  <= avail;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (step_reg != '0)
        begin
            dvd_reg <= {dvd_reg[PAGE_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (step_reg == STEP_W'(1))
            begin
                bpp_reg <= bpp_next;
            end
        end
    end

    assign geom.busy            = start_reg || (step_reg != '0);
    assign geom.clear           = we_data || we_page || we_align;
    assign geom.block_size      = size_reg;
    assign geom.page_bytes      = page_bytes_reg;
    assign geom.blocks_per_page = bpp_reg;

endmodule

// ===== sv/fbpa_front.sv =====
module fbpa_front #(
    parameter int MAX_BLOCKS_PER_PAGE = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             busy,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  fbpa_pkg::func_t                  func,
    input  logic [fbpa_pkg::HANDLE_W-1:0]    block_handle,
    output logic                             q_valid,
    output fbpa_pkg::req_t                   q_data,
    input  logic                             q_pop
);

    import fbpa_pkg::*;

    // Handle split by multiplying with a rounded-up reciprocal; exact for 12-bit handles.
    localparam int IDX_SHIFT   = $clog2(MAX_BLOCKS_PER_PAGE);
    localparam int RECIP_SHIFT = HANDLE_W + IDX_SHIFT;
    localparam int RECIP_W     = HANDLE_W + 2;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + MAX_BLOCKS_PER_PAGE - 1) / MAX_BLOCKS_PER_PAGE);
    localparam int PROD_W      = HANDLE_W + RECIP_W;
    localparam int FIFO_DEPTH  = 2;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int FILL_W      = $clog2(FIFO_DEPTH + 1);

    logic                 s1_valid_reg;
    func_t                s1_func_reg;
    logic [HANDLE_W-1:0]  s1_handle_reg;
    logic [HANDLE_W-1:0]  s1_page_reg;
    req_t                 fifo_mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;

    logic [PROD_W-1:0]    recip_prod;
    logic [HANDLE_W-1:0]  page_est;
    logic                 fifo_full;
    logic                 accept;
    logic                 s1_push;
    req_t                 s1_req;

    assign recip_prod = PROD_W'(block_handle) * PROD_W'(RECIP);
    assign page_est   = HANDLE_W'(recip_prod >> RECIP_SHIFT);

    assign fifo_full = fill_reg == FILL_W'(FIFO_DEPTH);
    assign in_ready  = !busy && (!s1_valid_reg || !fifo_full);
    assign accept    = in_valid && in_ready;
    assign s1_push   = s1_valid_reg && !fifo_full;

    assign s1_req.func = s1_func_reg;
    assign s1_req.page = s1_page_reg;
    assign s1_req.idx  = s1_handle_reg - HANDLE_W'(s1_page_reg * MAX_BLOCKS_PER_PAGE);

    assign fill_next = fill_reg + FILL_W'(s1_push) - FILL_W'(q_pop);

    assign q_valid = fill_reg != '0;
    assign q_data  = fifo_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_push)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg   <= func;
            s1_handle_reg <= block_handle;
            s1_page_reg   <= page_est;
        end
        if (s1_push)
        begin
            fifo_mem_reg[wr_ptr_reg] <= s1_req;
        end
    end

endmodule

// ===== sv/fbpa_back.sv =====
module fbpa_back #(
    parameter int MAX_PAGES           = 16,
    parameter int MAX_BLOCKS_PER_PAGE = 256,
    parameter int PAGE_HEADER_BYTES   = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fbpa_pkg::geom_t    geom,
    input  logic               q_valid,
    input  fbpa_pkg::req_t     q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output fbpa_pkg::result_t  out_res
);

    import fbpa_pkg::*;

    localparam int PG_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int IX_W      = $clog2(MAX_BLOCKS_PER_PAGE);
    localparam int PC_W      = $clog2(MAX_PAGES + 1);
    localparam int CARVE_W   = IX_W + 1;
    localparam int MEM_DEPTH = 1 << (PG_W + IX_W);

    typedef struct packed {
        logic            null_mark;
        logic [PG_W-1:0] page;
        logic [IX_W-1:0] idx;
    } link_t;

    back_state_t          state_reg, state_next;
    link_t                head_reg;
    link_t                link_rd_reg;
    link_t                link_mem [MEM_DEPTH];
    logic [PC_W-1:0]      pc_reg;
    logic [COUNT_W-1:0]   bc_reg;
    logic [COUNT_W-1:0]   fc_reg;
    logic [IX_W-1:0]      carve_reg;
    logic [HANDLE_W-1:0]  hnd_reg;
    logic [ADDR_W-1:0]    prod_page_reg;
    logic [ADDR_W-1:0]    prod_idx_reg;
    logic                 out_valid_reg;
    result_t              out_reg;

    logic                 is_free;
    logic                 no_page;
    logic                 free_ok;
    logic                 out_room;
    logic                 immediate;
    logic [CARVE_W-1:0]   carve_succ;
    logic                 carve_last;
    logic [COUNT_W-1:0]   fc_inc;
    logic [COUNT_W-1:0]   fc_dec;
    logic [COUNT_W:0]     fc_sum;
    logic [COUNT_W-1:0]   fc_add;
    logic [ADDR_W-1:0]    addr_sum;

    logic                 mem_we;
    logic [PG_W+IX_W-1:0] mem_waddr;
    link_t                mem_wdata;
    logic                 res_load;
    result_t              res;

    always_comb
    begin
        is_free    = q_data.func == FUNC_FREE;
        no_page    = (pc_reg >= PC_W'(MAX_PAGES)) || (geom.blocks_per_page == '0);
        free_ok    = (q_data.page < HANDLE_W'(pc_reg))
                  && ({1'b0, q_data.idx} < geom.blocks_per_page);
        out_room   = !out_valid_reg || out_ready;
        immediate  = is_free || (head_reg.null_mark && no_page);
        carve_succ = CARVE_W'(carve_reg) + CARVE_W'(1);
        carve_last = BPP_W'(carve_succ) == geom.blocks_per_page;
        fc_inc     = (fc_reg == COUNT_MAX) ? fc_reg : fc_reg + COUNT_W'(1);
        fc_dec     = (fc_reg == '0) ? fc_reg : fc_reg - COUNT_W'(1);
        fc_sum     = {1'b0, fc_reg} + (COUNT_W + 1)'(geom.blocks_per_page);
        fc_add     = (fc_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : fc_sum[COUNT_W-1:0];
        addr_sum   = prod_page_reg + ADDR_W'(PAGE_HEADER_BYTES) + prod_idx_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && !immediate)
                begin
                    state_next = head_reg.null_mark ? BK_CARVE : BK_POP;
                end
            end
            BK_CARVE:
            begin
                if (carve_last)
                begin
                    state_next = BK_SETTLE;
                end
            end
            BK_SETTLE: state_next = BK_POP;
            BK_POP:    state_next = BK_DONE;
            BK_DONE:
            begin
                if (out_room)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = {PG_W'(q_data.page), IX_W'(q_data.idx)};
        mem_wdata      = head_reg;
        res_load       = 1'b0;
        res.status     = ST_ALLOCATED;
        res.handle     = hnd_reg;
        res.addr       = addr_sum;
        res.pages      = PAGES_OUT_W'(pc_reg);
        res.total      = bc_reg;
        res.free       = fc_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = immediate ? out_room : 1'b1;
                    if (is_free)
                    begin
                        res_load   = out_room;
                        mem_we     = out_room && free_ok;
                        res.status = free_ok ? ST_FREED : ST_BAD_HANDLE;
                        res.handle = '0;
                        res.addr   = '0;
                        res.free   = free_ok ? fc_inc : fc_reg;
                    end
                    else if (immediate)
                    begin
                        res_load   = out_room;
                        res.status = ST_NO_PAGES;
                        res.handle = '0;
                        res.addr   = '0;
                    end
                end
            end
            BK_CARVE:
            begin
                mem_we              = 1'b1;
                mem_waddr           = {PG_W'(pc_reg), carve_reg};
                mem_wdata.null_mark = carve_last;
                mem_wdata.page      = PG_W'(pc_reg);
                mem_wdata.idx       = IX_W'(carve_succ);
            end
            BK_DONE:   res_load = out_room;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= BK_IDLE;
            head_reg.null_mark <= 1'b1;
            head_reg.page      <= '0;
            head_reg.idx       <= '0;
            pc_reg             <= '0;
            bc_reg             <= '0;
            fc_reg             <= '0;
            carve_reg          <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (geom.clear)
            begin
                head_reg.null_mark <= 1'b1;
                pc_reg             <= '0;
                bc_reg             <= '0;
                fc_reg             <= '0;
            end
            else
            begin
                case (state_reg)
                    BK_IDLE:
                    begin
                        if (q_pop && is_free && free_ok)
                        begin
                            head_reg.null_mark <= 1'b0;
                            head_reg.page      <= PG_W'(q_data.page);
                            head_reg.idx       <= IX_W'(q_data.idx);
                            fc_reg             <= fc_inc;
                        end
                        if (q_pop && !immediate)
                        begin
                            carve_reg <= '0;
                        end
                    end
                    BK_CARVE:
                    begin
                        carve_reg <= IX_W'(carve_succ);
                        if (carve_last)
                        begin
                            head_reg.null_mark <= 1'b0;
                            head_reg.page      <= PG_W'(pc_reg);
                            head_reg.idx       <= '0;
                            pc_reg             <= pc_reg + PC_W'(1);
                            bc_reg             <= bc_reg + COUNT_W'(geom.blocks_per_page);
                            fc_reg             <= fc_add;
                        end
                    end
                    BK_POP:
                    begin
                        head_reg <= link_rd_reg;
                        fc_reg   <= fc_dec;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_POP)
        begin
            hnd_reg       <= HANDLE_W'(head_reg.page) * HANDLE_W'(MAX_BLOCKS_PER_PAGE)
                           + HANDLE_W'(head_reg.idx);
            prod_page_reg <= ADDR_W'(head_reg.page) * ADDR_W'(geom.page_bytes);
            prod_idx_reg  <= ADDR_W'(head_reg.idx) * ADDR_W'(geom.block_size);
        end
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    // Link memory: one write port, one registered read of the current head.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        link_rd_reg <= link_mem[{head_reg.page, head_reg.idx}];
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

// ===== sv/fixed_block_pool_allocator.sv =====
// Channel   Direction  Handshake               Word
// in        sink       in_valid / in_ready     func, block_handle
// out       source     out_valid / out_ready   status, given_handle, given_address,
//                                              pages_in_use, total_blocks, free_blocks
// cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A free is answered straight from the back end's idle state; an allocate from a non-empty
// list takes the head read, the address products and the address sum. Every word first
// passes the front-end input stage. An allocate that finds the list empty first carves a
// page: one link memory write per block, since the link memory has one write port.
// After reset and after each register write, the block-size division runs while in_ready
// is low; configuration words are taken at any time.
// A stalled output holds one result; the front end keeps taking words until its
// two-entry queue and input stage are full.
module fixed_block_pool_allocator #(
    parameter int MAX_PAGES           = 16,
    parameter int MAX_BLOCKS_PER_PAGE = 256,
    parameter int BLOCK_HEADER_BYTES  = 8,
    parameter int PAGE_HEADER_BYTES   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  fbpa_pkg::func_t                     func,
    input  logic [fbpa_pkg::HANDLE_W-1:0]       block_handle,

    output logic                                out_valid,
    input  logic                                out_ready,
    output fbpa_pkg::status_t                   status,
    output logic [fbpa_pkg::HANDLE_W-1:0]       given_handle,
    output logic [fbpa_pkg::ADDR_W-1:0]         given_address,
    output logic [fbpa_pkg::PAGES_OUT_W-1:0]    pages_in_use,
    output logic [fbpa_pkg::COUNT_W-1:0]        total_blocks,
    output logic [fbpa_pkg::COUNT_W-1:0]        free_blocks,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import fbpa_pkg::*;

    geom_t   geom;
    logic    fifo_valid;
    req_t    fifo_data;
    logic    fifo_pop;
    result_t out_res;

    // The configuration unit holds the registers and derives the block size and the
    // number of blocks per page; any register write also empties the pool.
    fbpa_cfg #(
        .MAX_BLOCKS_PER_PAGE (MAX_BLOCKS_PER_PAGE),
        .BLOCK_HEADER_BYTES  (BLOCK_HEADER_BYTES),
        .PAGE_HEADER_BYTES   (PAGE_HEADER_BYTES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    // The front end registers each request, splits the handle into page and index,
    // and queues it for the back end.
    fbpa_front #(
        .MAX_BLOCKS_PER_PAGE (MAX_BLOCKS_PER_PAGE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .busy         (geom.busy),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .block_handle (block_handle),
        .q_valid      (fifo_valid),
        .q_data       (fifo_data),
        .q_pop        (fifo_pop)
    );

    // The back end owns the free list: link memory, head pointer, counters and the
    // output register.
    fbpa_back #(
        .MAX_PAGES           (MAX_PAGES),
        .MAX_BLOCKS_PER_PAGE (MAX_BLOCKS_PER_PAGE),
        .PAGE_HEADER_BYTES   (PAGE_HEADER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .q_valid   (fifo_valid),
        .q_data    (fifo_data),
        .q_pop     (fifo_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign status        = out_res.status;
    assign given_handle  = out_res.handle;
    assign given_address = out_res.addr;
    assign pages_in_use  = out_res.pages;
    assign total_blocks  = out_res.total;
    assign free_blocks   = out_res.free;

`ifndef SYNTHESIS
    // A register write restarts the size division, so no request may enter next cycle.
    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index == CFG_DATA_BYTES
            || cfg_index == CFG_PAGE_BYTES || cfg_index == CFG_ALIGN_LOG2))
        |=> !in_ready)
        else $error("request accepted while block geometry was being recomputed");

    // The back end only takes a request that the queue actually holds.
    a_pop_from_filled_queue: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> fifo_valid)
        else $error("request queue popped while empty");

    // Only a successful allocate carries a handle and an address.
    a_handle_only_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_ALLOCATED) |-> (given_handle == '0 && given_address == '0))
        else $error("handle or address reported on a result that is not an allocate");
`endif

endmodule

// ===== test/block_pool_checker.sv =====
`timescale 1ns / 1ps

module block_pool_checker #(
    parameter int MAX_PAGES           = 16,
    parameter int MAX_BLOCKS_PER_PAGE = 256,
    parameter int BLOCK_HEADER_BYTES  = 8,
    parameter int PAGE_HEADER_BYTES   = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    input  logic                                in_ready,
    input  fbpa_pkg::func_t                     func,
    input  logic [fbpa_pkg::HANDLE_W-1:0]       block_handle,

    input  logic                                out_valid,
    input  logic                                out_ready,
    input  fbpa_pkg::status_t                   status,
    input  logic [fbpa_pkg::HANDLE_W-1:0]       given_handle,
    input  logic [fbpa_pkg::ADDR_W-1:0]         given_address,
    input  logic [fbpa_pkg::PAGES_OUT_W-1:0]    pages_in_use,
    input  logic [fbpa_pkg::COUNT_W-1:0]        total_blocks,
    input  logic [fbpa_pkg::COUNT_W-1:0]        free_blocks,

    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [fbpa_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_data,

    output int                                  mismatches,
    output int                                  pending
);
    import fbpa_pkg::*;

    localparam int          SLOTS      = MAX_PAGES * MAX_BLOCKS_PER_PAGE;
    localparam logic [12:0] NO_BLOCK   = '1;
    localparam int unsigned COUNT_CEIL = 8191;

    logic [DATA_W-1:0]  data_bytes_q;
    logic [PAGE_W-1:0]  page_bytes_q;
    logic [ALIGN_W-1:0] align_q;
    logic [12:0]        link_mem [SLOTS];
    logic [12:0]        head;
    int unsigned        page_cnt;
    int unsigned        block_cnt;
    int unsigned        free_cnt;
    int unsigned        block_size;
    int unsigned        per_page;
    result_t            expected_replies [$];

    // Any register write empties the pool and recomputes the block geometry.
    function automatic void rebuild_pool();
        int unsigned need;
        int unsigned align;
        need = (data_bytes_q > BLOCK_HEADER_BYTES) ? data_bytes_q : BLOCK_HEADER_BYTES;
        align = 1 << align_q;
        block_size = (need + align - 1) & ~(align - 1);
        per_page = 0;
        if (page_bytes_q > PAGE_HEADER_BYTES)
            per_page = (page_bytes_q - PAGE_HEADER_BYTES) / block_size;
        if (per_page > MAX_BLOCKS_PER_PAGE)
            per_page = MAX_BLOCKS_PER_PAGE;
        head = NO_BLOCK;
        page_cnt = 0;
        block_cnt = 0;
        free_cnt = 0;
    endfunction

    function automatic result_t serve_request(input func_t op,
                                              input logic [HANDLE_W-1:0] handle);
        result_t         r;
        int unsigned     base;
        int unsigned     i;
        int unsigned     slot_page;
        int unsigned     slot_idx;
        longint unsigned addr;
        r = '0;
        if (op == FUNC_ALLOC) begin
            r.status = ST_ALLOCATED;
            if (head == NO_BLOCK) begin
                if (page_cnt >= MAX_PAGES || per_page == 0) begin
                    r.status = ST_NO_PAGES;
                end
                else begin
                    // A fresh page is threaded in address order.
                    base = page_cnt * MAX_BLOCKS_PER_PAGE;
                    for (i = 0; i + 1 < per_page; i++)
                        link_mem[base + i] = 13'(base + i + 1);
                    link_mem[base + per_page - 1] = NO_BLOCK;
                    head = 13'(base);
                    page_cnt++;
                    block_cnt += per_page;
                    free_cnt = (free_cnt + per_page > COUNT_CEIL) ? COUNT_CEIL
                                                                  : free_cnt + per_page;
                end
            end
            if (r.status == ST_ALLOCATED) begin
                slot_page = head / MAX_BLOCKS_PER_PAGE;
                slot_idx = head % MAX_BLOCKS_PER_PAGE;
                addr = longint'(slot_page) * page_bytes_q + PAGE_HEADER_BYTES
                       + longint'(slot_idx) * block_size;
                r.handle = head[HANDLE_W-1:0];
                r.addr = addr[ADDR_W-1:0];
                head = link_mem[head];
                if (free_cnt > 0)
                    free_cnt--;
            end
        end
        else begin
            slot_page = handle / MAX_BLOCKS_PER_PAGE;
            slot_idx = handle % MAX_BLOCKS_PER_PAGE;
            if (handle >= SLOTS || slot_page >= page_cnt || slot_idx >= per_page) begin
                r.status = ST_BAD_HANDLE;
            end
            else begin
                link_mem[handle] = head;
                head = {1'b0, handle};
                if (free_cnt < COUNT_CEIL)
                    free_cnt++;
                r.status = ST_FREED;
            end
        end
        r.pages = page_cnt[PAGES_OUT_W-1:0];
        r.total = block_cnt[COUNT_W-1:0];
        r.free = free_cnt[COUNT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : track
        result_t want;
        if (!rst_n) begin
            data_bytes_q = DATA_BYTES_RST;
            page_bytes_q = PAGE_BYTES_RST;
            align_q = ALIGN_LOG2_RST;
            rebuild_pool();
            expected_replies.delete();
            mismatches = 0;
            pending = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: no word expected, got status %0d handle %0d",
                             $time, status, given_handle);
                end
                else begin
                    want = expected_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("given_handle", 32'(want.handle), 32'(given_handle));
                    check_field("given_address", 32'(want.addr), 32'(given_address));
                    check_field("pages_in_use", 32'(want.pages), 32'(pages_in_use));
                    check_field("total_blocks", 32'(want.total), 32'(total_blocks));
                    check_field("free_blocks", 32'(want.free), 32'(free_blocks));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DATA_BYTES: begin
                        data_bytes_q = cfg_data[DATA_W-1:0];
                        rebuild_pool();
                    end
                    CFG_PAGE_BYTES: begin
                        page_bytes_q = cfg_data[PAGE_W-1:0];
                        rebuild_pool();
                    end
                    CFG_ALIGN_LOG2: begin
                        align_q = cfg_data[ALIGN_W-1:0];
                        rebuild_pool();
                    end
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_replies.push_back(serve_request(func, block_handle));
            pending = expected_replies.size();
        end
    end

endmodule

// ===== test/fixed_block_pool_allocator_tb.sv =====
`timescale 1ns / 1ps

module fixed_block_pool_allocator_tb;
    import fbpa_pkg::*;

    // Cycles the receiver refuses words in the pressure phase; long enough for the
    // output register, the front queue and the input stage all to fill.
    localparam int HOLD_CYCLES     = 200;
    // Quiet cycles after the last expected word at each drain, as before a register is written.
    localparam int SETTLE_CYCLES   = 8;
    // Quiet cycles at the very end, so that a stray extra word would be caught.
    localparam int TAIL_CYCLES     = 40;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int HANDLE_MAX      = (1 << HANDLE_W) - 1;
    // The slowest honest run is well under a tenth of this.
    localparam int LIMIT_NS        = 1_000_000;

    // The index past the end of the register list; a write there must do nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   in_valid = 1'b0;
    logic                   in_ready;
    func_t                  func = FUNC_ALLOC;
    logic [HANDLE_W-1:0]    block_handle = '0;

    logic                   out_valid;
    logic                   out_ready = 1'b0;
    status_t                status;
    logic [HANDLE_W-1:0]    given_handle;
    logic [ADDR_W-1:0]      given_address;
    logic [PAGES_OUT_W-1:0] pages_in_use;
    logic [COUNT_W-1:0]     total_blocks;
    logic [COUNT_W-1:0]     free_blocks;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int                     mismatches;
    int                     pending;

    // Percentages of idle cycles on each side, set per phase by the stimulus.
    int                     gap_pct = 0;
    int                     stall_pct = 0;
    // Bumped by the stimulus to ask the receiver for one long hold-off.
    int                     hold_req = 0;

    // Blocks handed out and not yet freed, so that most frees name a live block.
    logic [HANDLE_W-1:0]    live_handles [$];

    fixed_block_pool_allocator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .block_handle  (block_handle),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .given_handle  (given_handle),
        .given_address (given_address),
        .pages_in_use  (pages_in_use),
        .total_blocks  (total_blocks),
        .free_blocks   (free_blocks),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    block_pool_checker pool_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .block_handle  (block_handle),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .given_handle  (given_handle),
        .given_address (given_address),
        .pages_in_use  (pages_in_use),
        .total_blocks  (total_blocks),
        .free_blocks   (free_blocks),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin : clock_gen
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("fixed_block_pool_allocator_tb: done, errors");
        $finish;
    end

    // The receiver decides at each falling edge whether it will take a word at the
    // next rising edge. A change of hold_req starts a long refusal, which this
    // process counts down itself.
    initial
    begin : receiver
        int hold_left;
        int seen_req;
        hold_left = 0;
        seen_req = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req != seen_req)
            begin
                seen_req = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Every block the allocator hands out becomes a candidate for a later free.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && status == ST_ALLOCATED)
            live_handles.push_back(given_handle);
    end

    // Offers one word and returns once it has been taken. Any idle gap comes first,
    // with valid low; once raised, valid and the payload hold until acceptance.
    task automatic send_word(input func_t op, input logic [HANDLE_W-1:0] handle);
        int gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= op;
        block_handle <= handle;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stops offering words and waits until every expected word has come back.
    task automatic stop_and_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Registers are only written with the block drained; each write empties the
    // pool, so the list of live blocks is dropped too.
    task automatic reconfigure(input logic [CFG_DATA_W-1:0] data,
                               input logic [CFG_DATA_W-1:0] page,
                               input logic [CFG_DATA_W-1:0] align);
        stop_and_drain();
        write_reg(CFG_DATA_BYTES, data);
        write_reg(CFG_PAGE_BYTES, page);
        write_reg(CFG_ALIGN_LOG2, align);
        live_handles.delete();
    endtask

    // One random phase under one pool geometry. Half the words allocate, about a
    // third free a block that is really out, and the rest free handles in the low
    // pages or anywhere at all, which gives bad handles and double frees. With
    // pressure set, the receiver holds off for a long stretch a third of the way
    // in, and the sender waits for the block to empty two thirds of the way in.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] data,
                             input logic [CFG_DATA_W-1:0] page,
                             input logic [CFG_DATA_W-1:0] align,
                             input idle_mode_t mode,
                             input int count,
                             input bit pressure);
        int                  n;
        int                  pick;
        int                  slot;
        logic [HANDLE_W-1:0] handle;
        reconfigure(data, page, align);
        gap_pct = (mode == IDLE_SENDER) ? 61 : (mode == IDLE_BOTH) ? 33 : 0;
        stall_pct = (mode == IDLE_RECEIVER) ? 61 : (mode == IDLE_BOTH) ? 33 : 0;
        for (n = 0; n < count; n++)
        begin
            if (pressure && n == count / 3)
                hold_req++;
            if (pressure && n == 2 * count / 3)
                stop_and_drain();
            pick = $urandom_range(99);
            if (pick < 50 || (pick < 85 && live_handles.size() == 0))
            begin
                send_word(FUNC_ALLOC, HANDLE_W'($urandom_range(0, HANDLE_MAX)));
            end
            else if (pick < 85)
            begin
                slot = $urandom_range(0, live_handles.size() - 1);
                handle = live_handles[slot];
                // One live block in ten stays on the list, to be freed twice later.
                if ($urandom_range(9) != 0)
                    live_handles.delete(slot);
                send_word(FUNC_FREE, handle);
            end
            else if (pick < 93)
            begin
                send_word(FUNC_FREE, HANDLE_W'($urandom_range(0, 1023)));
            end
            else
            begin
                send_word(FUNC_FREE, HANDLE_W'($urandom_range(0, HANDLE_MAX)));
            end
        end
    endtask

    initial
    begin : stimulus
        int k;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed words under the reset geometry: 8-byte blocks, 256 to a page.
        // A free before any page exists is a bad handle.
        send_word(FUNC_FREE, 12'd0);
        // The first allocate carves page 0; the ignored handle field is all ones.
        send_word(FUNC_ALLOC, 12'hFFF);
        send_word(FUNC_ALLOC, 12'd0);
        // The list is last in, first out, so block 1 comes straight back.
        send_word(FUNC_FREE, 12'd1);
        send_word(FUNC_ALLOC, 12'd0);
        // A block that was never handed out, an unadded page and the top handle.
        send_word(FUNC_FREE, 12'd255);
        send_word(FUNC_FREE, 12'd256);
        send_word(FUNC_FREE, 12'hFFF);
        // A double free goes through unnoticed and links the block to itself.
        send_word(FUNC_FREE, 12'd254);
        send_word(FUNC_FREE, 12'd254);
        send_word(FUNC_ALLOC, 12'd0);
        send_word(FUNC_ALLOC, 12'd0);

        // A write to the unused index must leave the pool as it is.
        stop_and_drain();
        write_reg(CFG_UNUSED_INDEX, '1);
        send_word(FUNC_ALLOC, 12'd0);

        // A page smaller than its header holds no blocks at all.
        reconfigure(17'd8, 17'd5, 17'd3);
        send_word(FUNC_ALLOC, 12'd0);
        send_word(FUNC_FREE, 12'd0);

        // Largest payload, page and alignment: 32 KiB blocks, three to a page,
        // so the fourth allocate carves a second page.
        reconfigure(17'd8191, 17'd131071, 17'd15);
        repeat (4) send_word(FUNC_ALLOC, 12'd0);

        // One-byte payload, 16-byte page and alignment exponent zero: one block to a page.
        reconfigure(17'd1, 17'd16, 17'd0);
        send_word(FUNC_ALLOC, 12'd0);
        send_word(FUNC_ALLOC, 12'd0);

        // Four blocks to a page, so the pages run out within the phase.
        run_phase(17'd8, 17'd40, 17'd3, IDLE_NONE, ITEMS_PER_PHASE, 1'b0);
        // Blocks per page saturate; each new page is a long carve.
        run_phase(17'd1, 17'd4096, 17'd0, IDLE_SENDER, ITEMS_PER_PHASE, 1'b0);
        // Large pages push the byte address past its 20 bits.
        run_phase(17'd8191, 17'd131071, 17'd0, IDLE_RECEIVER, ITEMS_PER_PHASE, 1'b0);
        run_phase(17'd100, 17'd131071, 17'd15, IDLE_BOTH, ITEMS_PER_PHASE, 1'b0);
        // One block to a page with the long receiver hold-off and a mid-phase drain.
        run_phase(17'd5, 17'd16, 17'd1, IDLE_BOTH, ITEMS_PER_PHASE, 1'b1);
        // A page exactly the size of its header: every allocate runs out of pages.
        run_phase(17'd0, 17'd8, 17'd12, IDLE_RECEIVER, 40, 1'b0);
        run_phase(17'd0, 17'd20000, 17'd12, IDLE_SENDER, ITEMS_PER_PHASE, 1'b0);

        // Random geometries; stray high bits in the narrow registers must be dropped.
        for (k = 0; k < 4; k++)
        begin
            run_phase(CFG_DATA_W'($urandom_range(0, 131071)),
                      CFG_DATA_W'($urandom_range(16, 4096)),
                      CFG_DATA_W'($urandom_range(0, 131071)),
                      idle_mode_t'(k), ITEMS_PER_PHASE, 1'b0);
        end

        stop_and_drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("fixed_block_pool_allocator_tb: done, clean");
        else
            $display("fixed_block_pool_allocator_tb: done, errors");
        $finish;
    end

endmodule
